// File: rtl/reed_solomon_parity_encoder_defines.svh
// Assertion macros shared by the parity encoder RTL.
`ifndef REED_SOLOMON_PARITY_ENCODER_DEFINES_SVH
`define REED_SOLOMON_PARITY_ENCODER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define RSP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define RSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/rsp_pkg.sv
// Package: GF(2^8) arithmetic, generator polynomial builder and result item type.
package rsp_pkg;

  localparam int MaxRoots = 64;

  typedef logic [MaxRoots:0][7:0] gen_poly_t;

  typedef struct packed {
    logic [7:0] parity_byte;
    logic       parity_done;
  } result_t;

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
                                        input logic [8:0] poly);
    logic [8:0] x;
    logic [7:0] r;
    int         k;
    x = {1'b0, a};
    r = '0;
    for (k = 0; k < 8; k++) begin
      if (b[k]) r = r ^ x[7:0];
      x = {x[7:0], 1'b0};
      if (x[8]) x = x ^ poly;
      x[8] = 1'b0;
    end
    return r;
  endfunction

  // g(x) = prod (x - a^(first_root+i)), i = 0..nroots-1, a = 2
  function automatic gen_poly_t gen_poly(input int nroots, input logic [8:0] poly,
                                         input int first_root);
    gen_poly_t  g;
    logic [7:0] root;
    int         i;
    int         j;
    root = 8'd1;
    for (i = 0; i < first_root; i++) root = gf_mul(root, 8'd2, poly);
    g    = '0;
    g[0] = 8'd1;
    for (i = 0; i < nroots; i++) begin
      g[i+1] = 8'd1;
      for (j = i; j > 0; j--) g[j] = g[j-1] ^ gf_mul(g[j], root, poly);
      g[0] = gf_mul(g[0], root, poly);
      root = gf_mul(root, 8'd2, poly);
    end
    return g;
  endfunction

endpackage

// File: rtl/rsp_front.sv
// Front end: parity LFSR that absorbs one message item per cycle in which take is high.
module rsp_front #(
  parameter int                NROOTS = 32,
  parameter logic [8:0]        POLY   = 9'h11d,
  parameter rsp_pkg::gen_poly_t GEN   = '0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   take,
  input  logic [7:0]             data_byte,
  input  logic                   end_of_message,
  output logic                   snap_push,
  output logic [NROOTS-1:0][7:0] snap
);

  logic [NROOTS-1:0][7:0] parity_regs;
  logic [NROOTS-1:0][7:0] parity_regs_next;
  logic [7:0]             fb;

  assign fb = data_byte ^ parity_regs[0];

  always_comb begin
    for (int j = 0; j < NROOTS - 1; j++) begin
      parity_regs_next[j] = parity_regs[j+1] ^ rsp_pkg::gf_mul(fb, GEN[NROOTS-1-j], POLY);
    end
    parity_regs_next[NROOTS-1] = rsp_pkg::gf_mul(fb, GEN[0], POLY);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parity_regs <= '0;
    end else if (take) begin
      parity_regs <= end_of_message ? '0 : parity_regs_next;
    end
  end

  // finished parity set goes straight into the queue
  assign snap_push = take & end_of_message;
  assign snap      = parity_regs_next;

`include "reed_solomon_parity_encoder_defines.svh"

  `RSP_ASSERT_NEXT(a_clear_after_last, clk, rst, snap_push, parity_regs == '0, "LFSR not cleared after last item")

endmodule

// File: rtl/rsp_queue.sv
// Short queue of finished parity sets between front and back ends.
module rsp_queue #(
  parameter int WIDTH = 256,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  output logic             valid,
  output logic [WIDTH-1:0] rdata,
  input  logic             pop
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DEPTH-1:0][WIDTH-1:0] entries;
  logic [AW-1:0]               wr_ptr;
  logic [AW-1:0]               rd_ptr;
  logic [CW-1:0]               count;

  assign full  = (count == CW'(DEPTH));
  assign valid = (count != '0);
  assign rdata = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wdata;
  end

`include "reed_solomon_parity_encoder_defines.svh"

  `RSP_ASSERT_NOW(a_no_overflow, clk, rst, push, !full, "parity set pushed into full queue")
  `RSP_ASSERT_NOW(a_no_underflow, clk, rst, pop, valid, "parity set popped from empty queue")

endmodule

// File: rtl/rsp_back.sv
// Back end: serializes each parity set into result items, oldest byte first.
module rsp_back #(
  parameter int NROOTS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  logic [NROOTS-1:0][7:0] q_data,
  output logic                   q_pop,
  output logic                   out_valid,
  output rsp_pkg::result_t       out_item,
  input  logic                   pop
);

  localparam int CW = $clog2(NROOTS + 1);

  logic [NROOTS-1:0][7:0] sr;
  logic [CW-1:0]          cnt;
  logic                   advance;

  assign advance = !out_valid || pop;
  // reload on the cycle the final byte leaves so codewords run gap-free
  assign q_pop   = q_valid && ((cnt == '0) || ((cnt == CW'(1)) && advance));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) out_valid <= (cnt != '0);
      if (q_pop) begin
        cnt <= CW'(NROOTS);
      end else if (advance && (cnt != '0)) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && (cnt != '0)) begin
      out_item.parity_byte <= sr[0];
      out_item.parity_done <= (cnt == CW'(1));
    end
    if (q_pop) begin
      sr <= q_data;
    end else if (advance && (cnt != '0)) begin
      sr <= {8'h00, sr[NROOTS-1:1]};
    end
  end

`include "reed_solomon_parity_encoder_defines.svh"

  `RSP_ASSERT_NOW(a_cnt_range, clk, rst, 1'b1, cnt <= CW'(NROOTS), "byte count out of range")

endmodule

// File: rtl/reed_solomon_parity_encoder.sv
// Systematic Reed-Solomon parity encoder over GF(2^8), top level. One message item
// (data_byte, end_of_message) is taken per clock while full is low; the parity LFSR
// updates all NROOTS bytes in parallel through constant field multipliers. On the item
// marked end_of_message the finished parity set enters a two-deep queue and the LFSR
// clears in the same cycle, so the next message may follow at once. The serializer
// emits the NROOTS parity items at one per cycle unless the output is held by pop low,
// highest degree first, parity_done on the last; each set passes from the queue into
// the serializer shift register and then to the output register. full rises only when
// both queue slots hold parity sets waiting behind the one being serialized, which
// happens when messages shorter than NROOTS items arrive back to back or when a low
// pop stalls the serializer.
module reed_solomon_parity_encoder #(
  parameter int NROOTS     = 32,
  parameter int FIELD_POLY = 285,
  parameter int FIRST_ROOT = 0
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte,
  input  logic       end_of_message,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] parity_byte,
  output logic       parity_done
);

  localparam logic [8:0]         Poly     = FIELD_POLY[8:0];
  localparam rsp_pkg::gen_poly_t Gen      = rsp_pkg::gen_poly(NROOTS, Poly, FIRST_ROOT);
  localparam int                 SetWidth = NROOTS * 8;
  localparam int                 QDepth   = 2;

  logic                   take;
  logic                   snap_push;
  logic [NROOTS-1:0][7:0] snap;
  logic                   q_valid;
  logic [SetWidth-1:0]    q_data;
  logic                   q_pop;
  logic                   out_valid;
  rsp_pkg::result_t       out_item;

  assign take = push && !full;

  rsp_front #(
    .NROOTS(NROOTS),
    .POLY  (Poly),
    .GEN   (Gen)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .data_byte     (data_byte),
    .end_of_message(end_of_message),
    .snap_push     (snap_push),
    .snap          (snap)
  );

  rsp_queue #(
    .WIDTH(SetWidth),
    .DEPTH(QDepth)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (snap_push),
    .wdata(snap),
    .full (full),
    .valid(q_valid),
    .rdata(q_data),
    .pop  (q_pop)
  );

  rsp_back #(
    .NROOTS(NROOTS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_item (out_item),
    .pop      (pop)
  );

  assign empty       = !out_valid;
  assign parity_byte = out_item.parity_byte;
  assign parity_done = out_item.parity_done;

endmodule
